[hw/rtl/cew_pkg.sv]
// ----------------------------------------------------------------------------
// cew_pkg
// Shared types and codes of the completion epoch watermark tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cew_pkg;

   localparam int unsigned DEFAULT_WINDOW     = 64;
   localparam int unsigned DEFAULT_EPOCH_BITS = 32;
   localparam int unsigned FIELD_W            = 32;

   typedef enum logic [1:0] {
      ACT_RESERVE  = 2'd0,
      ACT_COMPLETE = 2'd1,
      ACT_CLEAR    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_IGNORED  = 2'd1,
      STAT_BEYOND   = 2'd2,
      STAT_DISABLED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MARK,
      ST_SHIFT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [FIELD_W-1:0] done_epoch;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] granted_epoch;
      logic [FIELD_W-1:0] completed_mark;
      logic [FIELD_W-1:0] last_granted;
   } rsp_item_type;

endpackage : cew_pkg

`default_nettype wire

[hw/rtl/completion_epoch_watermark.sv]
// ----------------------------------------------------------------------------
// completion_epoch_watermark
// Hands out increasing completion epochs and tracks the in-order completed
// watermark while completions arrive out of order.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   req_      in         req_valid/stall    req_item  (action, done_epoch)
//   rsp_      out        rsp_valid/stall    rsp_item  (status, granted_epoch,
//                                                      completed_mark,
//                                                      last_granted)
//   csr_      in         csr_wr_en          csr_wr_data (tracker_enabled)
//
// Sequencing: one item at a time. Reserve, clear and undefined actions pass
// the execute and reply steps; a rejected complete passes execute, mark and
// reply; a recorded complete adds the shift loop, which runs once for each
// position the watermark advances. In the loop one shared adder steps the
// watermark by one and the bitmap shifts down by one position per cycle.
// Reset: synchronous, active high; clears all epoch state and the bitmap at
// once, and disables the tracker. No clearing pass.
// Stalls: the result sits in an output register; the next item is accepted
// while it waits, and only the reply step waits for the register to free up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module completion_epoch_watermark
   import cew_pkg::*;
#(
   parameter int unsigned WINDOW     = DEFAULT_WINDOW,
   parameter int unsigned EPOCH_BITS = DEFAULT_EPOCH_BITS
) (
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         csr_wr_en,
   input  wire logic         csr_wr_data,

   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_item_type req_item,

   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_item_type rsp_item
);

   localparam int unsigned W     = EPOCH_BITS;
   localparam int unsigned IDX_W = $clog2(WINDOW);
   // wide enough for an epoch distance and for WINDOW itself
   localparam int unsigned CW    = (W > IDX_W + 1) ? W : IDX_W + 1;

   // sequencer
   state_type state_ff, state_in;

   // tracker state
   logic              enable_ff;
   logic [W-1:0]      next_epoch_ff, next_epoch_in;
   logic [W-1:0]      last_ff,       last_in;
   logic [W-1:0]      mark_ff,       mark_in;
   logic [WINDOW-1:0] pending_ff,    pending_in;

   // working registers for the item in flight
   req_item_type      item_ff;
   logic [W:0]        diff_ff,       diff_in;
   status_type        status_ff,     status_in;
   logic [W-1:0]      granted_ff,    granted_in;

   // output register
   logic              rsp_valid_ff,  rsp_valid_in;
   rsp_item_type      rsp_item_ff;

   // shared adder
   logic [W:0]        add_a, add_b, add_sum;
   logic              add_cin;

   logic              req_accept;
   logic              rsp_load;
   logic [W-1:0]      epoch_d;
   logic [CW-1:0]     off_wide;
   logic [IDX_W-1:0]  off_idx;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   // The complete epoch is taken modulo the epoch width.
   assign epoch_d  = W'(item_ff.done_epoch);

   // Offset of the epoch above the watermark, held from the subtract step.
   assign off_wide = CW'(diff_ff[W-1:0]);
   assign off_idx  = off_wide[IDX_W-1:0];

   // One adder serves reserve increment, the stale-check subtract and the
   // watermark step.
   assign add_sum  = add_a + add_b + (W+1)'(add_cin);

   assign rsp_load = (state_ff == ST_REPLY) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in      = state_ff;
      next_epoch_in = next_epoch_ff;
      last_in       = last_ff;
      mark_in       = mark_ff;
      pending_in    = pending_ff;
      diff_in       = diff_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;
      add_a         = '0;
      add_b         = '0;
      add_cin       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in  = STAT_OK;
            granted_in = '0;
            unique case (item_ff.action)
               ACT_RESERVE: begin
                  // next epoch + 1, skipping 0 on a wrap
                  add_a   = {1'b0, next_epoch_ff};
                  add_cin = 1'b1;
                  if (enable_ff) begin
                     granted_in = next_epoch_ff;
                     last_in    = next_epoch_ff;
                     next_epoch_in = (add_sum[W-1:0] == '0) ? W'(1) : add_sum[W-1:0];
                  end else begin
                     status_in = STAT_DISABLED;
                  end
                  state_in = ST_REPLY;
               end
               ACT_COMPLETE: begin
                  // d - mark - 1; the top bit is set when d <= mark (d = 0 too)
                  add_a    = {1'b0, epoch_d};
                  add_b    = {1'b1, ~mark_ff};
                  diff_in  = add_sum;
                  state_in = ST_MARK;
               end
               ACT_CLEAR: begin
                  next_epoch_in = W'(1);
                  last_in       = '0;
                  mark_in       = '0;
                  pending_in    = '0;
                  state_in      = ST_REPLY;
               end
               default: begin
                  status_in = STAT_IGNORED;
                  state_in  = ST_REPLY;
               end
            endcase
         end

         ST_MARK: begin
            priority if (diff_ff[W]) begin
               status_in = STAT_IGNORED;
               state_in  = ST_REPLY;
            end else if (off_wide >= CW'(WINDOW)) begin
               status_in = STAT_BEYOND;
               state_in  = ST_REPLY;
            end else begin
               pending_in = pending_ff | (WINDOW'(1) << off_idx);
               state_in   = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // Advance over the run of set bits at the bottom, one per cycle.
            if (pending_ff[0]) begin
               add_a      = {1'b0, mark_ff};
               add_cin    = 1'b1;
               mark_in    = add_sum[W-1:0];
               pending_in = pending_ff >> 1;
            end else begin
               state_in = ST_REPLY;
            end
         end

         ST_REPLY: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and tracker state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= 1'b0;
         next_epoch_ff <= W'(1);
         last_ff       <= '0;
         mark_ff       <= '0;
         pending_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_epoch_ff <= next_epoch_in;
         last_ff       <= last_in;
         mark_ff       <= mark_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_item;
      end
      diff_ff    <= diff_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      if (rsp_load) begin
         rsp_item_ff.status         <= status_ff;
         rsp_item_ff.granted_epoch  <= FIELD_W'(granted_ff);
         rsp_item_ff.completed_mark <= FIELD_W'(mark_ff);
         rsp_item_ff.last_granted   <= FIELD_W'(last_ff);
      end
   end

endmodule : completion_epoch_watermark

`default_nettype wire

[hw/rtl/cew_checker.sv]
// ----------------------------------------------------------------------------
// cew_checker
// Port-level checks on the completion epoch watermark tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cew_checker
   import cew_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_item_type req_item,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_item
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed or dropped");

   // Go busy after taking an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous one in flight");

   // Grant no epoch with a failing status.
   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status != STAT_OK) |-> rsp_item.granted_epoch == '0)
      else $error("epoch granted with a failing status");

   // Come out of reset idle and empty.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule : cew_checker

bind completion_epoch_watermark cew_checker u_cew_checker (.*);

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the completion epoch watermark tracker. A short
// table of hand-picked items covers the corner cases; the rest are random
// reserve/complete sequences with noise, with the tracker enabled and disabled.
// Every result is checked field by field, against a hand-written result or a local tracker model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import cew_pkg::*;

   // Action code with no meaning in the block; it must come back as ignored.
   localparam logic [1:0] ACT_UNDEFINED = 2'd3;

   localparam int unsigned WIN        = DEFAULT_WINDOW;
   localparam int unsigned PHASES     = 5;
   localparam int unsigned PHASE_LEN  = 130;
   localparam int unsigned OPEN_CAP   = 72;
   localparam int unsigned DRAIN_WAIT = 80;
   localparam int unsigned CYCLE_CAP  = 400_000;
   localparam int unsigned DIR_ROWS   = 24;

   typedef enum logic {
      ROW_ITEM,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic          csr_val;
      logic [1:0]    action;
      logic [31:0]   epoch;
      logic          typed;
      rsp_item_type  want;
   } plan_row_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         csr_wr_en   = 1'b0;
   logic         csr_wr_data = 1'b0;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_item_type req_item    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_item_type rsp_item;

   completion_epoch_watermark dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Tracker model state, mirrored from what the block should hold.
   logic           trk_on;
   logic [31:0]    next_ep;
   logic [31:0]    last_ep;
   logic [31:0]    mark;
   logic [WIN-1:0] pend;

   rsp_item_type   due_rsps [$];    // results owed by the block, oldest first
   logic [31:0]    open_eps [$];    // granted epochs not yet completed
   int unsigned    mismatches = 0;
   int unsigned    rsp_count  = 0;
   int unsigned    cycles     = 0;
   bit             quiet      = 1'b0;   // no idling on either side while set

   function automatic void clear_tracker();
      next_ep = 32'd1;
      last_ep = 32'd0;
      mark    = 32'd0;
      pend    = '0;
   endfunction

   // Work out the result of one item and advance the model state.
   function automatic rsp_item_type track_item(input req_item_type it);
      rsp_item_type r;
      logic [31:0]  off;
      int unsigned  run;
      r = '0;
      r.status = STAT_OK;
      case (it.action)
         ACT_RESERVE: begin
            if (trk_on) begin
               r.granted_epoch = next_ep;
               last_ep = next_ep;
               next_ep = next_ep + 32'd1;
               if (next_ep == 32'd0) next_ep = 32'd1;
            end else begin
               r.status = STAT_DISABLED;
            end
         end
         ACT_COMPLETE: begin
            if (it.done_epoch == 32'd0 || it.done_epoch <= mark) begin
               r.status = STAT_IGNORED;
            end else begin
               off = it.done_epoch - mark - 32'd1;
               if (off >= WIN) begin
                  r.status = STAT_BEYOND;
               end else begin
                  pend[off] = 1'b1;
                  // Slide the window over the run of set bits at the bottom.
                  run = 0;
                  while (run < WIN && pend[run]) run++;
                  pend = (run >= WIN) ? '0 : pend >> run;
                  mark = mark + run;
               end
            end
         end
         ACT_CLEAR: clear_tracker();
         default: r.status = STAT_IGNORED;
      endcase
      r.completed_mark = mark;
      r.last_granted   = last_ep;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("[%0t] result %0d %s: got %0h, want %0h", $time, rsp_count, what,
               got, want);
   endtask

   // Offer one item after a random gap, hold it until taken, then record
   // what it should produce.
   task automatic send_item(input req_item_type it, input bit typed,
                            input rsp_item_type want);
      int unsigned  gap;
      bit           took;
      rsp_item_type guess;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      guess = track_item(it);
      due_rsps.push_back(typed ? want : guess);
      if (it.action == ACT_RESERVE && guess.granted_epoch != 32'd0)
         open_eps.push_back(guess.granted_epoch);
      if (it.action == ACT_CLEAR)
         open_eps.delete();
   endtask

   // Write the enable bit only once the block has drained.
   task automatic write_enable(input logic v);
      req_valid <= 1'b0;
      while (due_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      trk_on = v;
   endtask

   // Mostly well-formed traffic: reserve epochs, complete them out of order.
   // The rest is stale, out-of-window, clear, undefined and raw noise.
   function automatic req_item_type next_random_item();
      req_item_type it;
      int unsigned  pick;
      int unsigned  idx;
      it.action     = ACT_RESERVE;
      it.done_epoch = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 38 && open_eps.size() >= OPEN_CAP) pick = 50;
      if (pick >= 38 && pick < 80 && open_eps.size() == 0) pick = 0;
      if (pick < 38) begin
         it.action = ACT_RESERVE;
      end else if (pick < 80) begin
         // Favor the oldest now and then so long runs collapse at once.
         idx = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, open_eps.size() - 1);
         it.action     = ACT_COMPLETE;
         it.done_epoch = open_eps[idx];
         open_eps.delete(idx);
      end else if (pick < 85) begin
         it.action     = ACT_COMPLETE;
         it.done_epoch = $urandom_range(0, mark);
      end else if (pick < 89) begin
         // Straddle the top edge of the window.
         it.action     = ACT_COMPLETE;
         it.done_epoch = mark + WIN + $urandom_range(0, 3);
      end else if (pick < 91) begin
         it.action = ACT_CLEAR;
      end else if (pick < 93) begin
         it.action = ACT_UNDEFINED;
      end else begin
         it.action = 2'($urandom_range(0, 3));
      end
      return it;
   endfunction

   // Directed table. Rows with typed set carry a hand-written result; the
   // others are checked against the model.
   plan_row_type plan [DIR_ROWS] = '{
      // Straight after reset, disabled.
      '{ROW_ITEM, 1'b0, ACT_RESERVE,   32'h0000_0000, 1'b1, '{STAT_DISABLED, 0, 0, 0}},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'h0000_0000, 1'b1, '{STAT_IGNORED,  0, 0, 0}},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'hFFFF_FFFF, 1'b1, '{STAT_BEYOND,   0, 0, 0}},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd65,        1'b1, '{STAT_BEYOND,   0, 0, 0}},
      // Top slot of the window, completed while disabled.
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd64,        1'b1, '{STAT_OK,       0, 0, 0}},
      '{ROW_ITEM, 1'b0, ACT_UNDEFINED, 32'hFFFF_FFFF, 1'b1, '{STAT_IGNORED,  0, 0, 0}},
      '{ROW_CSR,  1'b1, ACT_RESERVE,   32'h0,         1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_RESERVE,   32'hFFFF_FFFF, 1'b1, '{STAT_OK,       1, 0, 1}},
      '{ROW_ITEM, 1'b0, ACT_RESERVE,   32'h0,         1'b1, '{STAT_OK,       2, 0, 2}},
      '{ROW_ITEM, 1'b0, ACT_RESERVE,   32'h5555_AAAA, 1'b0, '0},
      // Out of order, a repeat of a pending epoch, then the gap fills.
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd2,         1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd2,         1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd1,         1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd1,         1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd3,         1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd66,        1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd68,        1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_CLEAR,     32'hFFFF_FFFF, 1'b1, '{STAT_OK,       0, 0, 0}},
      '{ROW_ITEM, 1'b0, ACT_RESERVE,   32'h0,         1'b1, '{STAT_OK,       1, 0, 1}},
      '{ROW_CSR,  1'b0, ACT_RESERVE,   32'h0,         1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_RESERVE,   32'h0,         1'b1, '{STAT_DISABLED, 0, 0, 1}},
      '{ROW_ITEM, 1'b0, ACT_COMPLETE,  32'd1,         1'b1, '{STAT_OK,       0, 1, 1}},
      '{ROW_CSR,  1'b1, ACT_RESERVE,   32'h0,         1'b0, '0},
      '{ROW_ITEM, 1'b0, ACT_CLEAR,     32'h0,         1'b1, '{STAT_OK,       0, 0, 0}}
   };

   // Enable setting for each random phase.
   bit phase_en [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

   // Stimulus: reset, directed table, random phases, then drain and judge.
   initial begin
      req_item_type it;
      trk_on = 1'b0;
      clear_tracker();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_enable(plan[i].csr_val);
         end else begin
            it.action     = plan[i].action;
            it.done_epoch = plan[i].epoch;
            send_item(it, plan[i].typed, plan[i].want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         write_enable(phase_en[p]);
         for (int k = 0; k < PHASE_LEN; k++) begin
            // Drop idling on both sides for some stretches.
            if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_item(next_random_item(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (due_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Result side: stall a random number of cycles per item, then take the
   // next result and check it against the oldest one owed.
   initial begin
      int unsigned  hold;
      bit           got;
      rsp_item_type seen;
      rsp_item_type want;
      @(negedge reset);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 10);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do begin
            @(negedge clock);
            got  = rsp_valid;
            seen = rsp_item;
            @(posedge clock);
         end while (!got);
         rsp_count++;
         if (due_rsps.size() == 0) begin
            report_mismatch("result with none owed", seen.completed_mark, 32'd0);
         end else begin
            want = due_rsps.pop_front();
            if (seen.status !== want.status)
               report_mismatch("status", 32'(seen.status), 32'(want.status));
            if (seen.granted_epoch !== want.granted_epoch)
               report_mismatch("granted_epoch", seen.granted_epoch, want.granted_epoch);
            if (seen.completed_mark !== want.completed_mark)
               report_mismatch("completed_mark", seen.completed_mark, want.completed_mark);
            if (seen.last_granted !== want.last_granted)
               report_mismatch("last_granted", seen.last_granted, want.last_granted);
         end
      end
   end

   // Hang guard: end the run if it goes far past the slowest correct run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_CAP) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
